// ===== sv/fsfa_pkg.sv =====
package fsfa_pkg;

  localparam logic [7:0] HDR_BYTE     = 8'hFE;
  localparam logic [7:0] LEN_BYTE     = 8'h04;
  localparam logic [7:0] TRAILER_BYTE = 8'hAA;
  localparam int unsigned FRAME_PAYLOAD = 7;
  localparam int unsigned STORE_DEPTH   = FRAME_PAYLOAD - 1;
  localparam int unsigned CNT_W         = $clog2(FRAME_PAYLOAD);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_OK     = 2'd1,
    KIND_CSUM   = 2'd2
  } kind_t;

  // Frame completion seen on the current item, from parser to accumulator.
  typedef struct packed {
    logic        frame_end;
    logic        csum_ok;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [7:0]  quality;
  } frame_evt_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] dx_total;
    logic signed [31:0] dy_total;
    logic [7:0]         quality;
  } result_t;

endpackage

// ===== sv/fsfa_parser.sv =====
module fsfa_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   op,
  input  logic [7:0]             rx_byte,
  output fsfa_pkg::frame_evt_t   evt
);
  import fsfa_pkg::*;

  phase_t             parse_phase, parse_phase_next;
  logic [CNT_W-1:0]   payload_count, payload_count_next;
  logic [7:0]         payload_bytes [STORE_DEPTH];
  logic               take_byte;
  logic               store_byte;
  logic [7:0]         csum;

  assign take_byte = advance && (op == OP_BYTE);

  always_comb begin
    parse_phase_next   = parse_phase;
    payload_count_next = payload_count;
    store_byte         = 1'b0;
    unique case (parse_phase)
      PH_LENGTH: begin
        if (rx_byte == LEN_BYTE) begin
          parse_phase_next   = PH_PAYLOAD;
          payload_count_next = '0;
        end else if (rx_byte != HDR_BYTE) begin
          parse_phase_next = PH_HEADER;
        end
      end
      PH_PAYLOAD: begin
        if (payload_count < CNT_W'(STORE_DEPTH)) begin
          store_byte         = 1'b1;
          payload_count_next = payload_count + 1'b1;
        end else begin
          parse_phase_next   = PH_HEADER;
          payload_count_next = '0;
        end
      end
      default: begin
        parse_phase_next = (rx_byte == HDR_BYTE) ? PH_LENGTH : PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_HEADER;
      payload_count <= '0;
    end else if (take_byte) begin
      parse_phase   <= parse_phase_next;
      payload_count <= payload_count_next;
    end
  end

  // Payload bytes need no reset: each is written before the trailer reads it.
  always_ff @(posedge clk) begin
    if (take_byte && store_byte) begin
      payload_bytes[payload_count] <= rx_byte;
    end
  end

  assign csum = payload_bytes[0] + payload_bytes[1] + payload_bytes[2] + payload_bytes[3];

  always_comb begin
    evt.frame_end = (op == OP_BYTE) && (parse_phase == PH_PAYLOAD)
                    && (payload_count == CNT_W'(STORE_DEPTH))
                    && (rx_byte == TRAILER_BYTE);
    evt.csum_ok   = (csum == payload_bytes[4]);
    evt.dx        = {payload_bytes[0], payload_bytes[1]};
    evt.dy        = {payload_bytes[2], payload_bytes[3]};
    evt.quality   = payload_bytes[5];
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    payload_count <= CNT_W'(STORE_DEPTH))
    else $error("payload count past frame length");

  a_count_only_in_payload: assert property (@(posedge clk) disable iff (rst)
    (parse_phase != PH_PAYLOAD) |-> (payload_count == '0))
    else $error("payload count nonzero outside payload phase");

  a_length_to_payload: assert property (@(posedge clk) disable iff (rst)
    (take_byte && parse_phase == PH_LENGTH && rx_byte == LEN_BYTE)
      |=> (parse_phase == PH_PAYLOAD && payload_count == '0))
    else $error("length byte did not start payload");
`endif

endmodule

// ===== sv/fsfa_accum.sv =====
module fsfa_accum (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   op,
  input  fsfa_pkg::frame_evt_t   evt,
  output logic                   res_valid,
  output fsfa_pkg::result_t      res
);
  import fsfa_pkg::*;

  logic [31:0] x_sum, x_sum_next;
  logic [31:0] y_sum, y_sum_next;
  logic [7:0]  last_quality, last_quality_next;
  logic        read_req;
  logic        frame_good;

  assign read_req   = (op == OP_READ);
  assign frame_good = evt.frame_end && evt.csum_ok;

  always_comb begin
    x_sum_next        = x_sum;
    y_sum_next        = y_sum;
    last_quality_next = last_quality;
    res_valid         = 1'b0;
    res.kind          = KIND_REPORT;
    res.dx_total      = '0;
    res.dy_total      = '0;
    res.quality       = last_quality;
    priority if (read_req) begin
      res_valid    = 1'b1;
      res.dx_total = x_sum;
      res.dy_total = y_sum;
      x_sum_next   = '0;
      y_sum_next   = '0;
    end else if (frame_good) begin
      x_sum_next        = x_sum + {{16{evt.dx[15]}}, evt.dx};
      y_sum_next        = y_sum + {{16{evt.dy[15]}}, evt.dy};
      last_quality_next = evt.quality;
      res_valid         = 1'b1;
      res.kind          = KIND_OK;
      res.quality       = evt.quality;
    end else if (evt.frame_end) begin
      res_valid = 1'b1;
      res.kind  = KIND_CSUM;
    end else begin
      // no result: hold sums and quality
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_sum        <= '0;
      y_sum        <= '0;
      last_quality <= '0;
    end else if (advance) begin
      x_sum        <= x_sum_next;
      y_sum        <= y_sum_next;
      last_quality <= last_quality_next;
    end
  end

`ifndef SYNTHESIS
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && read_req) |=> (x_sum == '0 && y_sum == '0))
    else $error("sums not cleared after read");

  a_csum_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (advance && !read_req && evt.frame_end && !evt.csum_ok)
      |=> ($stable(x_sum) && $stable(y_sum) && $stable(last_quality)))
    else $error("bad checksum frame changed sums");

  a_no_result_no_change: assert property (@(posedge clk) disable iff (rst)
    (advance && !res_valid) |=> ($stable(x_sum) && $stable(y_sum)))
    else $error("sums moved on an item with no result");
`endif

endmodule

// ===== sv/fsfa_out_reg.sv =====
module fsfa_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  fsfa_pkg::result_t   res,
  input  logic                m_tready,
  output logic                free,
  output logic                m_tvalid,
  output fsfa_pkg::result_t   held
);
  import fsfa_pkg::*;

  logic valid;

  assign free     = !valid || m_tready;
  assign m_tvalid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (m_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

`ifndef SYNTHESIS
  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result loaded over an undelivered one");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> valid)
    else $error("loaded result not shown");

  a_report_kinds_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && held.kind != KIND_REPORT) |-> (held.dx_total == '0 && held.dy_total == '0))
    else $error("frame result carries nonzero totals");
`endif

endmodule

// ===== sv/flow_sensor_frame_accumulator_core.sv =====
// Optical-flow sensor frame parser with motion accumulators.
//
// Slave channel (s_*): one item per handshake. s_tuser is the operation
// (0 = serial byte in s_tdata, 1 = read and clear the motion sums).
// Master channel (m_*): at most one result item per input item. m_tuser
// is the kind (0 = motion report, 1 = frame accepted, 2 = checksum error);
// m_tdata carries dx_total, dy_total and quality.
// Frames are 0xFE, 0x04, dx hi/lo, dy hi/lo, checksum, quality, 0xAA.
// Bytes outside a frame, and frames with a bad trailer, give no result.
//
// An accepted item lands in the input register, is parsed and accumulated
// as it advances, and its result is loaded into the output register that
// drives m_tvalid. Throughput is one item per cycle while the receiver
// does not stall: the input register and the output register each hold
// one item, and the parser next-state logic and the 32-bit sum adders
// sit between them.
// When the receiver stalls, the result holds in the output register and
// the input register fills; s_tready drops only once both are occupied.
// Reset (rst, synchronous) empties both registers, returns the parser to
// waiting for a header and clears sums and latched quality.
module flow_sensor_frame_accumulator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] dx_total, [63:32] dy_total, [71:64] quality
  output logic [1:0]  m_tuser    // [1:0] kind
);
  import fsfa_pkg::*;

  logic       in_valid;
  logic       in_op;
  logic [7:0] in_byte;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  frame_evt_t evt;
  result_t    res;
  result_t    held;

  // Advance the held item whenever the output register can take its result.
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Capture the item payload; no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  fsfa_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .op      (in_op),
    .rx_byte (in_byte),
    .evt     (evt)
  );

  fsfa_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .op        (in_op),
    .evt       (evt),
    .res_valid (res_valid),
    .res       (res)
  );

  fsfa_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .m_tready (m_tready),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .held     (held)
  );

  assign m_tuser = held.kind;
  assign m_tdata = {held.quality, held.dy_total, held.dx_total};

`ifndef SYNTHESIS
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_op) && $stable(in_byte)))
    else $error("input item lost while waiting");

  a_read_gives_report: assert property (@(posedge clk) disable iff (rst)
    (advance && in_op == OP_READ) |=> (m_tvalid && m_tuser == KIND_REPORT))
    else $error("read request produced no report");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled with empty input register");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;
  import fsfa_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = OP_BYTE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;

  flow_sensor_frame_accumulator_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser and accumulator mirror, advanced once per accepted item.
  phase_t                 frame_phase = PH_HEADER;
  logic [CNT_W-1:0]       frame_count = '0;
  logic [7:0]             frame_store [STORE_DEPTH];
  logic signed [31:0]     x_acc = '0;
  logic signed [31:0]     y_acc = '0;
  logic [7:0]             held_quality = '0;
  result_t                due_results [$];

  int  errors = 0;
  int  items_sent = 0;
  int  reports_seen = 0;
  int  frames_seen = 0;
  int  csum_errs_seen = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;

  task automatic parse_and_accumulate(input logic op, input logic [7:0] b);
    result_t    r;
    logic [7:0] csum;
    r = '0;
    if (op == OP_READ) begin
      r.kind     = KIND_REPORT;
      r.dx_total = x_acc;
      r.dy_total = y_acc;
      r.quality  = held_quality;
      due_results.push_back(r);
      x_acc = '0;
      y_acc = '0;
    end else begin
      case (frame_phase)
        PH_LENGTH: begin
          if (b == LEN_BYTE) begin
            frame_phase = PH_PAYLOAD;
            frame_count = '0;
          end else if (b != HDR_BYTE) begin
            frame_phase = PH_HEADER;
          end
        end
        PH_PAYLOAD: begin
          if (frame_count < STORE_DEPTH) begin
            frame_store[frame_count] = b;
            frame_count = frame_count + 1'b1;
          end else begin
            // trailer position: the frame closes here whatever the byte
            frame_phase = PH_HEADER;
            frame_count = '0;
            if (b == TRAILER_BYTE) begin
              csum = frame_store[0] + frame_store[1] + frame_store[2] + frame_store[3];
              if (csum != frame_store[4]) begin
                r.kind = KIND_CSUM;
              end else begin
                x_acc = x_acc + {{16{frame_store[0][7]}}, frame_store[0], frame_store[1]};
                y_acc = y_acc + {{16{frame_store[2][7]}}, frame_store[2], frame_store[3]};
                held_quality = frame_store[5];
                r.kind = KIND_OK;
              end
              r.quality = held_quality;
              due_results.push_back(r);
            end
          end
        end
        default: begin
          if (b == HDR_BYTE) frame_phase = PH_LENGTH;
          else frame_phase = PH_HEADER;
        end
      endcase
    end
  endtask

  // Offer one item, idling at random first; tvalid stays high afterwards.
  task automatic send_item(input logic op, input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    parse_and_accumulate(op, b);
    items_sent++;
  endtask

  // Send a whole frame; read_at places a read before that byte (-1 for none).
  task automatic send_frame(input int extra_hdr, input logic [15:0] dx,
                            input logic [15:0] dy, input logic [7:0] q,
                            input logic [7:0] csum_flip, input logic [7:0] trailer,
                            input int read_at);
    logic [7:0] seq [$];
    logic [7:0] csum;
    csum = dx[15:8] + dx[7:0] + dy[15:8] + dy[7:0];
    repeat (extra_hdr + 1) seq.push_back(HDR_BYTE);
    seq.push_back(LEN_BYTE);
    seq.push_back(dx[15:8]);
    seq.push_back(dx[7:0]);
    seq.push_back(dy[15:8]);
    seq.push_back(dy[7:0]);
    seq.push_back(csum ^ csum_flip);
    seq.push_back(q);
    seq.push_back(trailer);
    foreach (seq[i]) begin
      if (i == read_at) send_item(OP_READ, '0);
      send_item(OP_BYTE, seq[i]);
    end
  endtask

  // Hold off the sender until every outstanding result has been taken.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  function automatic logic [15:0] pick_motion();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_frame_extremes();
    send_item(OP_READ, 8'h00);           // read with nothing accumulated
    send_item(OP_BYTE, 8'h55);           // stray byte outside a frame
    send_item(OP_BYTE, HDR_BYTE);        // header, then an unknown length
    send_item(OP_BYTE, 8'h05);
    // repeated header, payload holding the header value, read mid-frame
    send_frame(1, 16'h7FFF, 16'h8000, 8'hFF, 8'h00, TRAILER_BYTE, 5);
    send_item(OP_READ, 8'hFF);
    send_frame(0, 16'h8000, 16'h7FFF, 8'h00, 8'h00, TRAILER_BYTE, -1);
    send_item(OP_READ, 8'h00);
  endtask

  task automatic test_bad_frames();
    send_frame(0, 16'h8000, 16'h7FFF, 8'h80, 8'h01, TRAILER_BYTE, -1);
    send_frame(0, 16'h1234, 16'h5678, 8'h42, 8'h00, 8'h55, -1);
    send_item(OP_READ, 8'h00);           // sums must still be zero
  endtask

  task automatic test_random_stream();
    int         sel;
    int         r;
    logic [7:0] flip;
    logic [7:0] trl;
    bit         paused;
    paused = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      no_idle = (items_sent >= 400 && items_sent < 700);
      if (items_sent >= 800 && !paused) begin
        paused = 1'b1;
        wait_drained();
      end
      sel = $urandom_range(99);
      if (sel < 70) begin
        r    = $urandom_range(99);
        flip = (r < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
        trl  = TRAILER_BYTE;
        if (r >= 12 && r < 20)
          do trl = 8'($urandom_range(255)); while (trl == TRAILER_BYTE);
        send_frame(($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0,
                   pick_motion(), pick_motion(), 8'($urandom_range(255)), flip, trl,
                   ($urandom_range(3) == 0) ? $urandom_range(0, 10) : -1);
      end else if (sel < 80) begin
        send_item(OP_READ, 8'($urandom_range(255)));
      end else if (sel < 88) begin
        send_item(OP_BYTE, 8'($urandom_range(255)));
      end else if (sel < 94) begin
        send_item(OP_BYTE, HDR_BYTE);
        send_item(OP_BYTE, 8'($urandom_range(255)));
      end else begin
        // truncated frame: the next bytes land in its payload
        send_item(OP_BYTE, HDR_BYTE);
        send_item(OP_BYTE, LEN_BYTE);
        repeat ($urandom_range(1, 6)) send_item(OP_BYTE, 8'($urandom_range(255)));
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver stalls at random except during the calm stretch.
  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d data %h",
                 $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (m_tuser != want.kind) begin
          $display("%0t: kind mismatch: expected %0d, actual %0d",
                   $time, want.kind, m_tuser);
          errors++;
        end
        if (m_tdata[31:0] != want.dx_total) begin
          $display("%0t: dx_total mismatch: expected %h, actual %h",
                   $time, want.dx_total, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[63:32] != want.dy_total) begin
          $display("%0t: dy_total mismatch: expected %h, actual %h",
                   $time, want.dy_total, m_tdata[63:32]);
          errors++;
        end
        if (m_tdata[71:64] != want.quality) begin
          $display("%0t: quality mismatch: expected %h, actual %h",
                   $time, want.quality, m_tdata[71:64]);
          errors++;
        end
        case (want.kind)
          KIND_REPORT: reports_seen++;
          KIND_OK:     frames_seen++;
          default:     csum_errs_seen++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_frame_extremes();
    test_bad_frames();
    wait_drained();
    test_random_stream();
    wait_drained();
    repeat (4) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_results.size());
      errors++;
    end
    $display("Sent %0d items in %0d cycles; checked %0d good frames, %0d checksum errors,",
             items_sent, cycles, frames_seen, csum_errs_seen);
    $display("and %0d motion reports; %0d mismatches.", reports_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
